>>> hw/rtl/ws2812_pkg.sv
package ws2812_pkg;

    // Pixel store size and frame geometry.
    localparam int MAX_LEDS     = 256;
    localparam int BITS_PER_LED = 24;
    localparam int PIX_AW       = $clog2(MAX_LEDS);
    localparam int LED_CW       = 9;
    localparam int BIT_CW       = 5;
    localparam int TICK_CW      = 10;

    // Configuration port geometry and register indexes.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 10;
    localparam logic [CFG_IW-1:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ONE_HIGH   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ONE_LOW    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LATCH      = 3'd5;

    // Command opcodes.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SET_ONE = 3'd1;
    localparam logic [2:0] OP_SET_ALL = 3'd2;
    localparam logic [2:0] OP_ON      = 3'd3;
    localparam logic [2:0] OP_OFF     = 3'd4;
    localparam logic [2:0] OP_TOGGLE  = 3'd5;
    localparam logic [2:0] OP_REFRESH = 3'd6;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_BUSY  = 2'd2;

    // Colour codes.
    localparam logic [2:0] COL_OFF     = 3'd0;
    localparam logic [2:0] COL_RED     = 3'd1;
    localparam logic [2:0] COL_GREEN   = 3'd2;
    localparam logic [2:0] COL_BLUE    = 3'd3;
    localparam logic [2:0] COL_YELLOW  = 3'd4;
    localparam logic [2:0] COL_CYAN    = 3'd5;
    localparam logic [2:0] COL_MAGENTA = 3'd6;
    localparam logic [2:0] COL_WHITE   = 3'd7;

    typedef logic [BITS_PER_LED-1:0] grb_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] led_index;
        logic [2:0] colour_code;
        logic [7:0] brightness;
    } in_item_t;

    typedef struct packed {
        logic       line_level;
        logic       busy_res;
        logic [1:0] status;
    } out_item_t;

    // Classified command as it travels from the front end to the sequencer.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] led_index;
        grb_t       grb;
    } cmd_t;

    // Builds the GRB word for a colour code; lit channels take the brightness.
    function automatic grb_t grb_word(logic [2:0] code, logic [7:0] lvl);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = '0;
        g = '0;
        b = '0;
        unique case (code)
            COL_RED:     r = lvl;
            COL_GREEN:   g = lvl;
            COL_BLUE:    b = lvl;
            COL_YELLOW:
            begin
                r = lvl;
                g = lvl;
            end
            COL_CYAN:
            begin
                g = lvl;
                b = lvl;
            end
            COL_MAGENTA:
            begin
                r = lvl;
                b = lvl;
            end
            COL_WHITE:
            begin
                r = lvl;
                g = lvl;
                b = lvl;
            end
            default: ;
        endcase
        return {g, r, b};
    endfunction

endpackage

>>> hw/rtl/ws2812_front.sv
module ws2812_front
    import ws2812_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    output logic     push,
    output cmd_t     push_cmd,
    input  logic     q_full
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    logic take;

    // The holding register drains into the queue whenever it has room.
    assign push     = hold_valid_reg && !q_full;
    assign push_cmd = hold_cmd_reg;
    assign in_stall = hold_valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Each transfer is classified here: the colour is turned into its GRB word.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_cmd_reg <= '{opcode:    in_item.opcode,
                              led_index: in_item.led_index,
                              grb:       grb_word(in_item.colour_code, in_item.brightness)};
        end
    end

endmodule

>>> hw/rtl/ws2812_queue.sv
module ws2812_queue
    import ws2812_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers wrap at the queue depth; the count follows pushes and pops.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/ws2812_back.sv
module ws2812_back
    import ws2812_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              q_empty,
    input  cmd_t              head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item
);

    // Sequencer states.
    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    // Bit phases of the serial line.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    // Register reset values.
    localparam logic [LED_CW-1:0]  LED_COUNT_RST = 9'd1;
    localparam logic [7:0]         ZERO_HIGH_RST = 8'd3;
    localparam logic [7:0]         ZERO_LOW_RST  = 8'd9;
    localparam logic [7:0]         ONE_HIGH_RST  = 8'd9;
    localparam logic [7:0]         ONE_LOW_RST   = 8'd3;
    localparam logic [TICK_CW-1:0] LATCH_RST     = 10'd500;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;

    logic [LED_CW-1:0]  led_count_reg;
    logic [7:0]         zero_high_reg;
    logic [7:0]         zero_low_reg;
    logic [7:0]         one_high_reg;
    logic [7:0]         one_low_reg;
    logic [TICK_CW-1:0] latch_reg;

    logic               led_on_reg;
    logic               led_on_next;
    logic               sending_reg;
    logic               sending_next;
    logic [LED_CW-1:0]  led_cnt_reg;
    logic [LED_CW-1:0]  led_cnt_next;
    logic [BIT_CW-1:0]  bit_cnt_reg;
    logic [BIT_CW-1:0]  bit_cnt_next;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [TICK_CW-1:0] tick_cnt_reg;
    logic [TICK_CW-1:0] tick_cnt_next;
    grb_t               shift_reg;
    grb_t               shift_next;
    logic [LED_CW-1:0]  fill_addr_reg;
    logic [LED_CW-1:0]  fill_addr_next;
    grb_t               fill_word_reg;
    grb_t               fill_word_next;

    grb_t               pix_ram [MAX_LEDS];
    logic [MAX_LEDS-1:0] pix_vld_reg;
    grb_t               rd_word_reg;
    logic               rd_vld_reg;
    logic               rd_en;
    logic [PIX_AW-1:0]  rd_addr;
    logic               wr_en;
    logic [PIX_AW-1:0]  wr_addr;
    grb_t               wr_data;

    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    logic [LED_CW-1:0]  eff_cnt;
    logic               slot_free;
    logic               exec;
    logic               start;
    logic               latch_sends;
    logic [TICK_CW-1:0] tick_dec;
    logic [LED_CW-1:0]  led_cnt_inc;
    logic [LED_CW-1:0]  fill_addr_inc;
    grb_t               load_word;

    // A bit duration of zero counts as one tick.
    function automatic logic [TICK_CW-1:0] bit_ticks(logic [7:0] v);
        return (v == '0) ? TICK_CW'(1) : {2'b00, v};
    endfunction

    assign eff_cnt       = (led_count_reg > LED_CW'(MAX_LEDS)) ? LED_CW'(MAX_LEDS) : led_count_reg;
    assign slot_free     = !out_valid_reg || !out_stall;
    assign exec          = (state_reg == S_RUN) && !q_empty && slot_free;
    assign pop           = exec;
    assign latch_sends   = (latch_reg != '0);
    assign tick_dec      = (tick_cnt_reg != '0) ? tick_cnt_reg - TICK_CW'(1) : '0;
    assign led_cnt_inc   = led_cnt_reg + LED_CW'(1);
    assign fill_addr_inc = fill_addr_reg + LED_CW'(1);
    assign load_word     = (led_on_reg && rd_vld_reg) ? rd_word_reg : '0;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

    // Main sequencer: executes one command, finishes a pixel load or sweeps a fill.
    always_comb
    begin
        state_next     = state_reg;
        led_on_next    = led_on_reg;
        sending_next   = sending_reg;
        led_cnt_next   = led_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        phase_next     = phase_reg;
        tick_cnt_next  = tick_cnt_reg;
        shift_next     = shift_reg;
        fill_addr_next = fill_addr_reg;
        fill_word_next = fill_word_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        start          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            S_RUN:
            begin
                if (exec)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = STAT_OK;
                    if (head.opcode == OP_TICK)
                    begin
                        // Line level and busy describe the tick before it advances time.
                        out_item_next.line_level = sending_reg && (phase_reg == PH_HIGH);
                        out_item_next.busy_res   = sending_reg;
                        if (sending_reg)
                        begin
                            tick_cnt_next = tick_dec;
                            if (tick_dec == '0)
                            begin
                                unique case (phase_reg)
                                    PH_HIGH:
                                    begin
                                        phase_next    = PH_LOW;
                                        tick_cnt_next = shift_reg[BITS_PER_LED-1]
                                                      ? bit_ticks(one_low_reg)
                                                      : bit_ticks(zero_low_reg);
                                    end
                                    PH_LOW:
                                    begin
                                        shift_next = {shift_reg[BITS_PER_LED-2:0], 1'b0};
                                        if (bit_cnt_reg == BIT_CW'(BITS_PER_LED - 1))
                                        begin
                                            bit_cnt_next = '0;
                                            led_cnt_next = led_cnt_inc;
                                            if (led_cnt_inc >= eff_cnt)
                                            begin
                                                sending_next  = latch_sends;
                                                phase_next    = latch_sends ? PH_LATCH : PH_IDLE;
                                                tick_cnt_next = latch_reg;
                                            end
                                            else
                                            begin
                                                rd_en      = 1'b1;
                                                rd_addr    = led_cnt_inc[PIX_AW-1:0];
                                                phase_next = PH_HIGH;
                                                state_next = S_LOAD;
                                            end
                                        end
                                        else
                                        begin
                                            bit_cnt_next  = bit_cnt_reg + BIT_CW'(1);
                                            phase_next    = PH_HIGH;
                                            tick_cnt_next = shift_reg[BITS_PER_LED-2]
                                                          ? bit_ticks(one_high_reg)
                                                          : bit_ticks(zero_high_reg);
                                        end
                                    end
                                    default:
                                    begin
                                        // End of the latch gap closes the frame.
                                        sending_next  = 1'b0;
                                        phase_next    = PH_IDLE;
                                        tick_cnt_next = '0;
                                    end
                                endcase
                            end
                        end
                    end
                    else
                    begin
                        if ((head.opcode != OP_UNUSED) && sending_reg)
                        begin
                            out_item_next.status = STAT_BUSY;
                        end
                        else
                        begin
                            unique case (head.opcode)
                                OP_SET_ONE:
                                begin
                                    if ({1'b0, head.led_index} >= eff_cnt)
                                    begin
                                        out_item_next.status = STAT_RANGE;
                                    end
                                    else
                                    begin
                                        wr_en   = 1'b1;
                                        wr_addr = head.led_index[PIX_AW-1:0];
                                        wr_data = head.grb;
                                    end
                                end
                                OP_SET_ALL:
                                begin
                                    if (eff_cnt != '0)
                                    begin
                                        fill_word_next = head.grb;
                                        fill_addr_next = '0;
                                        state_next     = S_FILL;
                                    end
                                end
                                OP_ON:
                                begin
                                    if (!led_on_reg)
                                    begin
                                        led_on_next = 1'b1;
                                        start       = 1'b1;
                                    end
                                end
                                OP_OFF:
                                begin
                                    if (led_on_reg)
                                    begin
                                        led_on_next = 1'b0;
                                        start       = 1'b1;
                                    end
                                end
                                OP_TOGGLE:
                                begin
                                    led_on_next = !led_on_reg;
                                    start       = 1'b1;
                                end
                                OP_REFRESH:
                                begin
                                    start = 1'b1;
                                end
                                default: ;
                            endcase
                        end

                        // A new frame reads the first pixel, else enters the latch gap or idle.
                        if (start)
                        begin
                            sending_next = 1'b1;
                            led_cnt_next = '0;
                            if (eff_cnt == '0)
                            begin
                                sending_next  = latch_sends;
                                phase_next    = latch_sends ? PH_LATCH : PH_IDLE;
                                tick_cnt_next = latch_reg;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                phase_next = PH_HIGH;
                                state_next = S_LOAD;
                            end
                        end

                        // Commands report the line as it stands after them.
                        out_item_next.line_level = sending_next && (phase_next == PH_HIGH);
                        out_item_next.busy_res   = sending_next;
                    end
                end
            end
            S_LOAD:
            begin
                // Pixel word is back from the store: start its first bit.
                shift_next    = load_word;
                bit_cnt_next  = '0;
                phase_next    = PH_HIGH;
                tick_cnt_next = load_word[BITS_PER_LED-1] ? bit_ticks(one_high_reg)
                                                          : bit_ticks(zero_high_reg);
                state_next    = S_RUN;
            end
            S_FILL:
            begin
                // One store entry per cycle.
                wr_en          = 1'b1;
                wr_addr        = fill_addr_reg[PIX_AW-1:0];
                wr_data        = fill_word_reg;
                fill_addr_next = fill_addr_inc;
                if (fill_addr_inc >= eff_cnt)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // Control and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            led_on_reg    <= 1'b0;
            sending_reg   <= 1'b0;
            led_cnt_reg   <= '0;
            bit_cnt_reg   <= '0;
            phase_reg     <= PH_IDLE;
            tick_cnt_reg  <= '0;
            shift_reg     <= '0;
            fill_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            led_on_reg    <= led_on_next;
            sending_reg   <= sending_next;
            led_cnt_reg   <= led_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            tick_cnt_reg  <= tick_cnt_next;
            shift_reg     <= shift_next;
            fill_addr_reg <= fill_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and fill word.
    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        fill_word_reg <= fill_word_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            latch_reg     <= LATCH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= cfg_data[LED_CW-1:0];
                CFG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                CFG_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                CFG_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                CFG_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                CFG_LATCH:     latch_reg     <= cfg_data[TICK_CW-1:0];
                default: ;
            endcase
        end
    end

    // Pixel store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pix_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= pix_ram[rd_addr];
            rd_vld_reg  <= pix_vld_reg[rd_addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            pix_vld_reg[wr_addr] <= 1'b1;
        end
    end

endmodule

>>> hw/rtl/ws2812_strip_driver_top.sv
// Serial driver for a strip of WS2812 LEDs, one command or tick per input transfer.
// Input channel (in_valid, in_stall, in_item): a tick advances the line by one time-base
// tick; other opcodes set one pixel, set all pixels, or switch the strip on, off, toggle
// it or refresh it. Each input transfer yields exactly one result transfer on the output
// channel (out_valid, out_stall, out_item) with the line level, busy flag and status.
// Configuration (cfg_we, cfg_index, cfg_data) writes the LED count, bit timings and latch
// gap; write it only while no command is in flight.
// An item passes an input register, the command queue and the result register before its
// result is offered. Throughput: one item per cycle while the output does not stall and
// no pixel load or fill is under way. A tick that moves on to the next LED and a command
// that starts a frame are followed by a load state for the registered read of the pixel
// store. Set all then enters a fill state, one store write per addressed LED.
// A stalled output holds its result; the sequencer then stops, the queue fills and the
// input stalls in turn. Reset empties the queue, clears the pixel store through its
// valid bits in the same cycle, and restores the configuration defaults.
module ws2812_strip_driver_top
    import ws2812_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t head;

    // Front end: takes transfers and classifies them.
    ws2812_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // Command queue between front end and sequencer.
    ws2812_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // Sequencer with pixel store and serial line state.
    ws2812_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

>>> hw/rtl/ws2812_checker.sv
module ws2812_checker
    import ws2812_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // The data line is never high while no frame is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.busy_res |-> !out_item.line_level)
        else $error("line high while idle");

    // A command rejected as busy must report a frame in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STAT_BUSY) |-> out_item.busy_res)
        else $error("busy rejection without a frame");

    // A range error can only come from an idle strip.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STAT_RANGE) |-> !out_item.busy_res && !out_item.line_level)
        else $error("range error reported during a frame");

endmodule

bind ws2812_strip_driver_top ws2812_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
